@@ rtl/rbs_pkg.sv @@
// Shared constants, types and control structs for the RGB565 bit-plane slicer.
package rbs_pkg;

    // Group geometry: one pixel per screen, one RGB565 word per pixel.
    localparam int SCREEN_COUNT = 16;
    localparam int SCREEN_W     = $clog2(SCREEN_COUNT);
    localparam int WORD_W       = 16;
    localparam int PLANE_W      = $clog2(WORD_W);

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 24;
    localparam int OUT_PAD_W    = OUT_TDATA_W - WORD_W - PLANE_W;

    localparam logic [SCREEN_W-1:0] LAST_SCREEN = SCREEN_W'(SCREEN_COUNT - 1);
    localparam logic [PLANE_W-1:0]  LAST_PLANE  = PLANE_W'(WORD_W - 1);

    typedef logic [WORD_W-1:0] rgb565_t;

    // Write request into the plane buffer: one screen's packed word.
    typedef struct packed {
        logic                en;
        logic                bank;
        logic [SCREEN_W-1:0] screen;
        rgb565_t             word;
    } rbs_wr_t;

    // Read request from the plane buffer: one plane of the drained bank.
    typedef struct packed {
        logic               bank;
        logic [PLANE_W-1:0] plane;
    } rbs_rd_t;

endpackage

@@ rtl/rbs_pack.sv @@
// RGB888 to RGB565 packer.
module rbs_pack
    import rbs_pkg::*;
(
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output rgb565_t    word
);

    // Keep the top five red bits, top six green bits and top five blue bits.
    assign word = {red[7:3], green[7:2], blue[7:3]};

endmodule

@@ rtl/rbs_plane_buf.sv @@
// Double-buffered plane store that transposes screen words into bit planes on write.
module rbs_plane_buf
    import rbs_pkg::*;
(
    input  logic        aclk,
    input  rbs_wr_t     wr,
    input  rbs_rd_t     rd,
    output logic [SCREEN_COUNT-1:0] rd_word
);

    // Two banks of plane words; plane q holds bit 15-q of every screen.
    logic [SCREEN_COUNT-1:0] plane_mem [2][WORD_W];

    // Each written word scatters its bits into one column of all plane words.
    // Screen s lands in bit 15-s so that screen 0 ends up in the MSB.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            for (int q = 0; q < WORD_W; q++) begin
                plane_mem[wr.bank][q][LAST_SCREEN - wr.screen] <= wr.word[WORD_W-1-q];
            end
        end
    end

    // One plane word of the bank being drained.
    assign rd_word = plane_mem[rd.bank][rd.plane];

endmodule

@@ rtl/rgb565_bitplane_slicer_top.sv @@
// Top level of the RGB565 bit-plane slicer: stream handshakes and group control.
//
// Pixels arrive one per transaction in screen order 0 to 15 and are packed to
// RGB565. The sixteenth pixel of a group completes it, and the block then
// sends sixteen plane words, plane 0 (red MSB) first, with tlast on plane 15;
// plane word bit 15-s is screen s. A pixel is taken every cycle but for the
// stall below: the store has two banks, so one group fills while the
// previous one drains. The first plane word of a group is valid the cycle
// after its sixteenth pixel is taken. The input stalls only on the
// sixteenth pixel of a group while the other bank still holds planes not
// yet taken, which is decided by the single output register stage (plane
// counter and busy flag).
module rgb565_bitplane_slicer_top
    import rbs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input pixel stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    // Output plane stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // plane_word[15:0], plane_index[19:16], zero
    output logic                   m_axis_tlast    // last_plane
);

    logic [SCREEN_W-1:0] screen_reg, screen_next;
    logic                fill_bank_reg, fill_bank_next;
    logic                busy_reg, busy_next;
    logic [PLANE_W-1:0]  plane_reg, plane_next;

    logic                    s_fire;
    logic                    m_fire;
    logic                    group_done;
    logic                    drain_end;
    rgb565_t                 pix_word;
    rbs_wr_t                 wr;
    rbs_rd_t                 rd;
    logic [SCREEN_COUNT-1:0] plane_word;

    // Handshake events.
    assign s_fire     = s_axis_tvalid && s_axis_tready;
    assign m_fire     = m_axis_tvalid && m_axis_tready;
    assign group_done = s_fire && (screen_reg == LAST_SCREEN);
    assign drain_end  = m_fire && (plane_reg == LAST_PLANE);

    // The closing pixel of a group needs the drain bank to be free.
    assign s_axis_tready = (screen_reg != LAST_SCREEN) || !busy_reg || drain_end;

    // Pixel packing.
    rbs_pack u_pack (
        .red   (s_axis_tdata[7:0]),
        .green (s_axis_tdata[15:8]),
        .blue  (s_axis_tdata[23:16]),
        .word  (pix_word)
    );

    // Plane buffer access.
    assign wr.en     = s_fire;
    assign wr.bank   = fill_bank_reg;
    assign wr.screen = screen_reg;
    assign wr.word   = pix_word;
    assign rd.bank   = !fill_bank_reg;
    assign rd.plane  = plane_reg;

    rbs_plane_buf u_buf (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_word (plane_word)
    );

    // Group and drain control.
    always_comb begin
        screen_next    = screen_reg;
        fill_bank_next = fill_bank_reg;
        busy_next      = busy_reg;
        plane_next     = plane_reg;
        if (s_fire) begin
            screen_next = screen_reg + 1'b1;
        end
        if (group_done) begin
            fill_bank_next = !fill_bank_reg;
            busy_next      = 1'b1;
            plane_next     = '0;
        end else if (drain_end) begin
            busy_next = 1'b0;
        end else if (m_fire) begin
            plane_next = plane_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_reg    <= '0;
            fill_bank_reg <= 1'b0;
            busy_reg      <= 1'b0;
            plane_reg     <= '0;
        end else begin
            screen_reg    <= screen_next;
            fill_bank_reg <= fill_bank_next;
            busy_reg      <= busy_next;
            plane_reg     <= plane_next;
        end
    end

    // Output stream.
    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, plane_reg, plane_word};
    assign m_axis_tlast  = (plane_reg == LAST_PLANE);

endmodule

@@ rtl/rbs_checker.sv @@
// Port-level checker for the RGB565 bit-plane slicer, bound to the top level.
module rbs_checker
    import rbs_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    // A stalled output transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Output payload changed while stalled.");

    // The last flag marks plane 15 and only plane 15.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[19:16] == LAST_PLANE)))
        else $error("Last flag does not match plane index.");

    // Within a group the planes follow each other without gaps.
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[19:16] == PLANE_W'($past(m_axis_tdata[19:16]) + 1'b1)))
        else $error("Plane sequence broken within a group.");

    // Padding bits of the output word stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[23:20] == '0))
        else $error("Output padding bits are not zero.");

    // Nothing is offered right after reset.
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("Output valid after reset.");

endmodule

bind rgb565_bitplane_slicer_top rbs_checker u_rbs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
